FILE: sv/hcbd_pkg.sv
// Shared types, codes and character helpers for the chunked body decoder.
// No dependencies; used by hcbd_step and http_chunked_body_decoder_core.
`default_nettype none

package hcbd_pkg;

    localparam int SIZE_BITS_DEF = 32;

    localparam logic [7:0] CHR_CR   = 8'h0D;
    localparam logic [7:0] CHR_LF   = 8'h0A;
    localparam logic [7:0] CHR_SEMI = 8'h3B;

    typedef enum logic [1:0] {
        CMD_BYTE    = 2'd0,
        CMD_CLOSE   = 2'd1,
        CMD_RESTART = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_PROGRESS = 2'd0,
        ST_COMPLETE = 2'd1,
        ST_INVALID  = 2'd2
    } status_t;

    typedef enum logic [6:0] {
        PH_SIZE    = 7'b0000001,
        PH_EXT     = 7'b0000010,
        PH_DATA    = 7'b0000100,
        PH_DATA_CR = 7'b0001000,
        PH_DATA_LF = 7'b0010000,
        PH_TRAILER = 7'b0100000,
        PH_END     = 7'b1000000
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic        digits_seen;
        logic        after_space;
        logic        cr_pending;
        logic [1:0]  trl_cnt;
        status_t     status;
    } ctl_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        out_valid;
        status_t     status;
    } res_t;

    localparam ctl_t CTL_RESET = '{
        phase:       PH_SIZE,
        digits_seen: 1'b0,
        after_space: 1'b0,
        cr_pending:  1'b0,
        trl_cnt:     2'd0,
        status:      ST_PROGRESS
    };

    // {valid, value} of a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd0;
        case (c) inside
            [8'h30:8'h39]: v = {1'b1, 4'(c - 8'h30)};
            [8'h61:8'h66]: v = {1'b1, 4'(c - 8'h57)};
            [8'h41:8'h46]: v = {1'b1, 4'(c - 8'h37)};
            default:       v = 5'd0;
        endcase
        return v;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
    endfunction

endpackage

`default_nettype wire

FILE: sv/hcbd_step.sv
// Next-state and result logic for one encoded byte or command.
// Depends on hcbd_pkg for codes, state struct and character helpers.
`default_nettype none

module hcbd_step #(
    parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
    input  wire logic [1:0]           cmd,
    input  wire logic [7:0]           in_byte,
    input  wire hcbd_pkg::ctl_t       ctl_cur,
    input  wire logic [SIZE_BITS-1:0] chunk_cur,
    output hcbd_pkg::ctl_t            ctl_nxt,
    output logic [SIZE_BITS-1:0]      chunk_nxt,
    output hcbd_pkg::res_t            res
);

    hcbd_pkg::cmd_t cmd_e;
    logic [4:0]     hexv;
    logic           size_full;

    assign cmd_e     = hcbd_pkg::cmd_t'(cmd);
    assign hexv      = hcbd_pkg::hex_value(in_byte);
    assign size_full = |chunk_cur[SIZE_BITS-1 -: 4];

    always_comb
    begin
        ctl_nxt       = ctl_cur;
        chunk_nxt     = chunk_cur;
        res.out_byte  = 8'd0;
        res.out_valid = 1'b0;
        case (cmd_e)
            hcbd_pkg::CMD_RESTART:
            begin
                ctl_nxt   = hcbd_pkg::CTL_RESET;
                chunk_nxt = '0;
            end
            hcbd_pkg::CMD_CLOSE:
            begin
                if (ctl_cur.status == hcbd_pkg::ST_PROGRESS)
                begin
                    ctl_nxt.status = hcbd_pkg::ST_INVALID;
                    ctl_nxt.phase  = hcbd_pkg::PH_END;
                end
            end
            hcbd_pkg::CMD_BYTE:
            begin
                if (ctl_cur.status == hcbd_pkg::ST_PROGRESS)
                begin
                    case (ctl_cur.phase)
                        hcbd_pkg::PH_SIZE, hcbd_pkg::PH_EXT:
                        begin
                            if (ctl_cur.cr_pending && in_byte == hcbd_pkg::CHR_LF)
                            begin
                                // end of size line
                                ctl_nxt.cr_pending = 1'b0;
                                if (!ctl_cur.digits_seen)
                                begin
                                    ctl_nxt.status = hcbd_pkg::ST_INVALID;
                                    ctl_nxt.phase  = hcbd_pkg::PH_END;
                                end
                                else
                                begin
                                    ctl_nxt.digits_seen = 1'b0;
                                    ctl_nxt.after_space = 1'b0;
                                    if (chunk_cur == '0)
                                    begin
                                        ctl_nxt.phase   = hcbd_pkg::PH_TRAILER;
                                        ctl_nxt.trl_cnt = 2'd2;
                                    end
                                    else
                                    begin
                                        ctl_nxt.phase = hcbd_pkg::PH_DATA;
                                    end
                                end
                            end
                            else
                            begin
                                // a lone CR counts as whitespace
                                ctl_nxt.cr_pending = 1'b0;
                                if (ctl_cur.cr_pending && ctl_cur.digits_seen
                                    && ctl_cur.phase == hcbd_pkg::PH_SIZE)
                                begin
                                    ctl_nxt.after_space = 1'b1;
                                end
                                if (in_byte == hcbd_pkg::CHR_CR)
                                begin
                                    ctl_nxt.cr_pending = 1'b1;
                                end
                                else if (ctl_cur.phase == hcbd_pkg::PH_SIZE)
                                begin
                                    if (hcbd_pkg::is_space(in_byte))
                                    begin
                                        if (ctl_cur.digits_seen)
                                        begin
                                            ctl_nxt.after_space = 1'b1;
                                        end
                                    end
                                    else if (in_byte == hcbd_pkg::CHR_SEMI)
                                    begin
                                        if (!ctl_cur.digits_seen)
                                        begin
                                            ctl_nxt.status = hcbd_pkg::ST_INVALID;
                                            ctl_nxt.phase  = hcbd_pkg::PH_END;
                                        end
                                        else
                                        begin
                                            ctl_nxt.phase = hcbd_pkg::PH_EXT;
                                        end
                                    end
                                    else if (!hexv[4] || ctl_nxt.after_space || size_full)
                                    begin
                                        ctl_nxt.status = hcbd_pkg::ST_INVALID;
                                        ctl_nxt.phase  = hcbd_pkg::PH_END;
                                    end
                                    else
                                    begin
                                        chunk_nxt = {chunk_cur[SIZE_BITS-5:0], hexv[3:0]};
                                        ctl_nxt.digits_seen = 1'b1;
                                    end
                                end
                            end
                        end
                        hcbd_pkg::PH_DATA:
                        begin
                            res.out_byte  = in_byte;
                            res.out_valid = 1'b1;
                            chunk_nxt     = chunk_cur - SIZE_BITS'(1);
                            if (chunk_cur == SIZE_BITS'(1))
                            begin
                                ctl_nxt.phase = hcbd_pkg::PH_DATA_CR;
                            end
                        end
                        hcbd_pkg::PH_DATA_CR:
                        begin
                            if (in_byte == hcbd_pkg::CHR_CR)
                            begin
                                ctl_nxt.phase = hcbd_pkg::PH_DATA_LF;
                            end
                            else
                            begin
                                ctl_nxt.status = hcbd_pkg::ST_INVALID;
                                ctl_nxt.phase  = hcbd_pkg::PH_END;
                            end
                        end
                        hcbd_pkg::PH_DATA_LF:
                        begin
                            if (in_byte == hcbd_pkg::CHR_LF)
                            begin
                                ctl_nxt.phase = hcbd_pkg::PH_SIZE;
                                chunk_nxt     = '0;
                            end
                            else
                            begin
                                ctl_nxt.status = hcbd_pkg::ST_INVALID;
                                ctl_nxt.phase  = hcbd_pkg::PH_END;
                            end
                        end
                        hcbd_pkg::PH_TRAILER:
                        begin
                            // track progress through CR LF CR LF
                            if (!ctl_cur.trl_cnt[0])
                            begin
                                if (in_byte == hcbd_pkg::CHR_CR)
                                begin
                                    ctl_nxt.trl_cnt = ctl_cur.trl_cnt + 2'd1;
                                end
                                else
                                begin
                                    ctl_nxt.trl_cnt = 2'd0;
                                end
                            end
                            else if (in_byte == hcbd_pkg::CHR_LF)
                            begin
                                if (ctl_cur.trl_cnt == 2'd3)
                                begin
                                    ctl_nxt.status  = hcbd_pkg::ST_COMPLETE;
                                    ctl_nxt.phase   = hcbd_pkg::PH_END;
                                    ctl_nxt.trl_cnt = 2'd0;
                                end
                                else
                                begin
                                    ctl_nxt.trl_cnt = ctl_cur.trl_cnt + 2'd1;
                                end
                            end
                            else
                            begin
                                ctl_nxt.trl_cnt = (in_byte == hcbd_pkg::CHR_CR) ? 2'd1 : 2'd0;
                            end
                        end
                        default:
                        begin
                            ctl_nxt = ctl_cur;
                        end
                    endcase
                end
            end
            default:
            begin
                ctl_nxt = ctl_cur;
            end
        endcase
        res.status = ctl_nxt.status;
    end

endmodule

`default_nettype wire

FILE: sv/http_chunked_body_decoder_core.sv
// Chunked body decoder: one encoded byte or command in, one result out per transfer.
// Each item passes through the input register and then the result register; throughput
// 1 item per cycle while res_stall does not hold the result. The input register feeds
// hcbd_step; state and result register load from it once the result stage is free. Reset
// (rst_n low, asynchronous) empties both stages and returns the decoder to the start of a
// size line with status in progress. Depends on hcbd_pkg and hcbd_step.
`default_nettype none

module http_chunked_body_decoder_core #(
    parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] command,
    input  wire logic [7:0] in_byte,
    output logic            res_valid,
    input  wire logic       res_stall,
    output logic [7:0]      out_byte,
    output logic            out_valid,
    output logic [1:0]      status
);

    logic                  in_valid_reg;
    logic [1:0]            cmd_reg;
    logic [7:0]            byte_reg;
    hcbd_pkg::ctl_t        ctl_reg;
    hcbd_pkg::ctl_t        ctl_next;
    logic [SIZE_BITS-1:0]  chunk_reg;
    logic [SIZE_BITS-1:0]  chunk_next;
    hcbd_pkg::res_t        res_next;
    logic                  res_valid_reg;
    hcbd_pkg::res_t        res_reg;
    logic                  out_free;
    logic                  advance;

    assign out_free = !res_valid_reg || !res_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;

    hcbd_step #(
        .SIZE_BITS (SIZE_BITS)
    ) u_step (
        .cmd       (cmd_reg),
        .in_byte   (byte_reg),
        .ctl_cur   (ctl_reg),
        .chunk_cur (chunk_reg),
        .ctl_nxt   (ctl_next),
        .chunk_nxt (chunk_next),
        .res       (res_next)
    );

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            cmd_reg  <= command;
            byte_reg <= in_byte;
        end
    end

    // decoder state, advance once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg   <= hcbd_pkg::CTL_RESET;
            chunk_reg <= '0;
        end
        else if (advance)
        begin
            ctl_reg   <= ctl_next;
            chunk_reg <= chunk_next;
        end
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            res_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign out_byte  = res_reg.out_byte;
    assign out_valid = res_reg.out_valid;
    assign status    = res_reg.status;

endmodule

`default_nettype wire

FILE: bench/hcbd_stream_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the chunked body decoder: predicts one result per input transfer
// and compares it with the result channel. Depends on hcbd_pkg.

module hcbd_stream_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_stall,
    input  wire logic [1:0] command,
    input  wire logic [7:0] in_byte,
    input  wire logic       res_valid,
    input  wire logic       res_stall,
    input  wire logic [7:0] out_byte,
    input  wire logic       out_valid,
    input  wire logic [1:0] status,
    output int              errors,
    output int              outstanding,
    output int              payload_bytes,
    output int              bodies_ok,
    output int              bodies_bad
);
    import hcbd_pkg::*;

    // Decoder state as the predictor sees it
    phase_t      ph;
    logic [31:0] chunk_left;
    logic        digits_seen;
    logic        after_space;
    logic        cr_pending;
    logic [1:0]  trl_cnt;
    status_t     body_st;

    res_t        expected_q[$];

    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return {1'b1, c[3:0]};
        if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
            return {1'b1, c[3:0] + 4'd9};
        return 5'd0;
    endfunction

    function automatic logic white(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    task automatic clear_decoder();
        ph          = PH_SIZE;
        chunk_left  = '0;
        digits_seen = 1'b0;
        after_space = 1'b0;
        cr_pending  = 1'b0;
        trl_cnt     = 2'd0;
        body_st     = ST_PROGRESS;
    endtask

    task automatic abort_body();
        body_st = ST_INVALID;
        ph      = PH_END;
    endtask

    // One character of the size line, CR pairing already resolved
    task automatic size_char(input logic [7:0] c);
        logic [4:0] nib;
        nib = nibble_of(c);
        if (ph == PH_EXT)
            return;
        if (white(c))
        begin
            if (digits_seen)
                after_space = 1'b1;
        end
        else if (c == CHR_SEMI)
        begin
            if (!digits_seen)
                abort_body();
            else
                ph = PH_EXT;
        end
        else if (!nib[4] || after_space || chunk_left[31:28] != 4'd0)
        begin
            abort_body();
        end
        else
        begin
            chunk_left  = {chunk_left[27:0], nib[3:0]};
            digits_seen = 1'b1;
        end
    endtask

    task automatic end_of_size_line();
        cr_pending = 1'b0;
        if (!digits_seen)
        begin
            abort_body();
        end
        else
        begin
            digits_seen = 1'b0;
            after_space = 1'b0;
            if (chunk_left == 32'd0)
            begin
                ph      = PH_TRAILER;
                // the size line's own CR LF counts toward the blank line
                trl_cnt = 2'd2;
            end
            else
            begin
                ph = PH_DATA;
            end
        end
    endtask

    task automatic decode_byte(input logic [7:0] c, output logic [7:0] ob, output logic ov);
        ob = 8'h00;
        ov = 1'b0;
        case (ph)
            PH_SIZE, PH_EXT:
            begin
                if (cr_pending && c == CHR_LF)
                begin
                    end_of_size_line();
                end
                else
                begin
                    // a lone CR is plain whitespace
                    if (cr_pending)
                    begin
                        cr_pending = 1'b0;
                        size_char(CHR_CR);
                    end
                    if (c == CHR_CR)
                        cr_pending = 1'b1;
                    else
                        size_char(c);
                end
            end
            PH_DATA:
            begin
                ob         = c;
                ov         = 1'b1;
                chunk_left = chunk_left - 32'd1;
                if (chunk_left == 32'd0)
                    ph = PH_DATA_CR;
            end
            PH_DATA_CR:
            begin
                if (c == CHR_CR)
                    ph = PH_DATA_LF;
                else
                    abort_body();
            end
            PH_DATA_LF:
            begin
                if (c == CHR_LF)
                begin
                    ph         = PH_SIZE;
                    chunk_left = '0;
                end
                else
                begin
                    abort_body();
                end
            end
            PH_TRAILER:
            begin
                if (!trl_cnt[0])
                begin
                    trl_cnt = (c == CHR_CR) ? trl_cnt + 2'd1 : 2'd0;
                end
                else if (c == CHR_LF)
                begin
                    if (trl_cnt == 2'd3)
                    begin
                        body_st = ST_COMPLETE;
                        ph      = PH_END;
                        trl_cnt = 2'd0;
                    end
                    else
                    begin
                        trl_cnt = trl_cnt + 2'd1;
                    end
                end
                else
                begin
                    trl_cnt = (c == CHR_CR) ? 2'd1 : 2'd0;
                end
            end
            default: ;
        endcase
    endtask

    task automatic step_decoder(input logic [1:0] cmd, input logic [7:0] c, output res_t r);
        status_t    prior;
        logic [7:0] ob;
        logic       ov;
        prior = body_st;
        ob    = 8'h00;
        ov    = 1'b0;
        case (cmd)
            CMD_RESTART: clear_decoder();
            CMD_CLOSE:   if (body_st == ST_PROGRESS) abort_body();
            CMD_BYTE:    if (body_st == ST_PROGRESS) decode_byte(c, ob, ov);
            default: ;
        endcase
        r.out_byte  = ob;
        r.out_valid = ov;
        r.status    = body_st;
        if (ov)
            payload_bytes++;
        if (prior == ST_PROGRESS && body_st == ST_COMPLETE)
            bodies_ok++;
        if (prior == ST_PROGRESS && body_st == ST_INVALID)
            bodies_bad++;
    endtask

    task automatic note_mismatch(input string what, input res_t want, input res_t got);
        errors++;
        if (errors <= 10)
            $display("%0t: %s: expected %h/%b/%0d, got %h/%b/%0d (byte/valid/status)",
                     $realtime, what, want.out_byte, want.out_valid, want.status,
                     got.out_byte, got.out_valid, got.status);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        res_t want;
        res_t got;
        if (!rst_n)
        begin
            clear_decoder();
            expected_q.delete();
        end
        else
        begin
            // compare before predicting: a result never belongs to this cycle's input
            if (res_valid && !res_stall)
            begin
                got.out_byte  = out_byte;
                got.out_valid = out_valid;
                got.status    = status_t'(status);
                if (expected_q.size() == 0)
                begin
                    note_mismatch("result with nothing pending", '0, got);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.out_byte !== want.out_byte || got.out_valid !== want.out_valid
                        || got.status !== want.status)
                        note_mismatch("result differs", want, got);
                end
            end
            if (in_valid && !in_stall)
            begin
                step_decoder(command, in_byte, want);
                expected_q.insert(expected_q.size(), want);
            end
        end
        outstanding = expected_q.size();
    end

endmodule

FILE: bench/http_chunked_body_decoder_core_tb.sv
`timescale 1ns / 100ps
// Top of the chunked body decoder bench: builds encoded bodies, noise and commands,
// drives them with random gaps and stalls, and reports the verdict.
// Depends on hcbd_pkg, hcbd_stream_checker and http_chunked_body_decoder_core.

module http_chunked_body_decoder_core_tb;
    import hcbd_pkg::*;

    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int         NUM_ITEMS = 1750;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data;
    } enc_item_t;

    typedef enum int {
        FLAW_NONE,
        FLAW_EMPTY,
        FLAW_OVERFLOW,
        FLAW_BAD_CHAR,
        FLAW_SPACE_DIGIT,
        FLAW_HUGE,
        FLAW_NO_DATA_CRLF,
        FLAW_CLOSE,
        FLAW_TRUNC,
        FLAW_FLIP
    } flaw_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] command;
    logic [7:0] in_byte;
    logic       res_valid;
    logic       res_stall;
    logic [7:0] out_byte;
    logic       out_valid;
    logic [1:0] status;

    int fail_count;
    int pending;
    int n_payload;
    int n_ok;
    int n_bad;

    enc_item_t stim_q[$];
    int        n_directed;
    bit        no_idle;
    int        stall_left;

    http_chunked_body_decoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .in_byte   (in_byte),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .out_byte  (out_byte),
        .out_valid (out_valid),
        .status    (status)
    );

    hcbd_stream_checker scoreboard (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .in_byte       (in_byte),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .out_byte      (out_byte),
        .out_valid     (out_valid),
        .status        (status),
        .errors        (fail_count),
        .outstanding   (pending),
        .payload_bytes (n_payload),
        .bodies_ok     (n_ok),
        .bodies_bad    (n_bad)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #10ms;
        $display("http_chunked_body_decoder_core: mismatch");
        $finish;
    end

    // Mostly short idle runs, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] base;
        base = ($urandom_range(0, 1) != 0) ? 8'h41 : 8'h61;
        return (n < 4'd10) ? 8'h30 + n : base + n - 8'd10;
    endfunction

    function automatic logic [31:0] pick_chunk_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(20, 60);
        return $urandom_range(1, 6);
    endfunction

    task automatic put(input logic [1:0] cmd, input logic [7:0] b);
        enc_item_t it;
        it.cmd  = cmd;
        it.data = b;
        stim_q.insert(stim_q.size(), it);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put(CMD_BYTE, s[i]);
    endtask

    task automatic put_crlf();
        put(CMD_BYTE, CHR_CR);
        put(CMD_BYTE, CHR_LF);
    endtask

    // Free text byte: never let it close a line by pairing LF with a stray CR
    task automatic put_free(input logic [7:0] b);
        if (b == CHR_LF && stim_q.size() > 0 && stim_q[$].cmd == CMD_BYTE
            && stim_q[$].data == CHR_CR)
            b = 8'h20;
        put(CMD_BYTE, b);
    endtask

    task automatic put_blank(input int n);
        logic [7:0] ws[6];
        ws = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
        for (int i = 0; i < n; i++)
            put_free(ws[$urandom_range(0, 5)]);
    endtask

    task automatic put_hex(input logic [31:0] v, input int pad);
        int nd;
        nd = 8;
        while (nd > 1 && v[nd*4-1 -: 4] == 4'd0)
            nd--;
        repeat (pad)
            put(CMD_BYTE, "0");
        for (int j = nd - 1; j >= 0; j--)
            put(CMD_BYTE, hex_char(v[j*4 +: 4]));
    endtask

    task automatic put_body();
        int          n_chunks;
        int          flaw_at;
        int          first;
        int          p;
        flaw_t       flaw;
        logic [31:0] sz;
        logic [7:0]  junk[7];
        enc_item_t   tmp;
        junk  = '{"g", "-", "Z", ":", 8'h00, 8'h80, 8'hFF};
        first = stim_q.size();
        put(CMD_RESTART, 8'($urandom));
        n_chunks = $urandom_range(0, 3);
        flaw = ($urandom_range(0, 2) == 0) ? flaw_t'($urandom_range(FLAW_EMPTY, FLAW_FLIP))
                                           : FLAW_NONE;
        flaw_at = $urandom_range(0, n_chunks);
        for (int k = 0; k <= n_chunks; k++)
        begin
            sz = (k == n_chunks) ? 32'd0 : pick_chunk_len();
            if (k == flaw_at && flaw == FLAW_HUGE)
                sz = 32'hFFFF_FFFF;
            put_blank(($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
            if (k == flaw_at)
            begin
                case (flaw)
                    FLAW_EMPTY:
                    begin
                        if ($urandom_range(0, 1) != 0)
                            put_text(";");
                        else
                            put_crlf();
                        return;
                    end
                    FLAW_OVERFLOW:
                    begin
                        put(CMD_BYTE, hex_char(4'($urandom_range(1, 15))));
                        put_hex($urandom | 32'h1000_0000, 0);
                        put_crlf();
                        return;
                    end
                    FLAW_BAD_CHAR:
                    begin
                        if ($urandom_range(0, 1) != 0)
                            put_hex(sz, 0);
                        put(CMD_BYTE, junk[$urandom_range(0, 6)]);
                        return;
                    end
                    FLAW_SPACE_DIGIT:
                    begin
                        put_hex(sz, 0);
                        put_blank(1);
                        put(CMD_BYTE, hex_char(4'($urandom)));
                        return;
                    end
                    default: ;
                endcase
            end
            put_hex(sz, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0);
            put_blank(($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
            if ($urandom_range(0, 3) == 0)
            begin
                put_text(";");
                repeat ($urandom_range(0, 5))
                    put_free(8'($urandom));
            end
            put_crlf();
            if (sz != 32'd0)
            begin
                if (k == flaw_at && flaw == FLAW_HUGE)
                begin
                    // largest size that fits: send a little of it and leave it open
                    repeat ($urandom_range(3, 10))
                        put(CMD_BYTE, 8'($urandom));
                    return;
                end
                repeat (sz)
                    put(CMD_BYTE, 8'($urandom));
                if (k == flaw_at && flaw == FLAW_NO_DATA_CRLF)
                begin
                    if ($urandom_range(0, 1) != 0)
                    begin
                        put(CMD_BYTE, CHR_CR);
                        put(CMD_BYTE, 8'($urandom_range(11, 255)));
                    end
                    else
                    begin
                        put(CMD_BYTE, 8'($urandom_range(14, 255)));
                    end
                    return;
                end
                put_crlf();
            end
        end
        // trailer section after the zero-size line
        if ($urandom_range(0, 1) != 0)
        begin
            repeat ($urandom_range(1, 2))
            begin
                repeat ($urandom_range(1, 6))
                    put_free(8'($urandom));
                put_crlf();
            end
        end
        put_crlf();
        p = $urandom_range(first + 1, stim_q.size() - 1);
        case (flaw)
            FLAW_CLOSE, FLAW_TRUNC:
            begin
                while (stim_q.size() > p)
                    void'(stim_q.pop_back());
                if (flaw == FLAW_CLOSE)
                    put(CMD_CLOSE, 8'($urandom));
            end
            FLAW_FLIP:
            begin
                tmp      = stim_q[p];
                tmp.data = 8'($urandom);
                stim_q[p] = tmp;
            end
            default: ;
        endcase
        if ($urandom_range(0, 5) == 0)
        begin
            p = $urandom_range(first + 1, stim_q.size());
            tmp.cmd  = CMD_SPARE;
            tmp.data = 8'($urandom);
            stim_q.insert(p, tmp);
        end
        // noise past the end of the body
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 4))
                put(2'($urandom_range(0, 3)), 8'($urandom));
    endtask

    task automatic build_stimulus();
        put(CMD_RESTART, 8'h00);
        // whitespace, one-byte chunk with an extension
        put(CMD_BYTE, 8'h09);
        put_text("1 ;x");
        put_crlf();
        put(CMD_BYTE, 8'hFF);
        put_crlf();
        // last chunk with one trailer line
        put_text("0");
        put_crlf();
        put_text("T");
        put_crlf();
        put_crlf();
        // ignored once complete
        put(CMD_BYTE, 8'h00);
        put(CMD_SPARE, 8'hFF);
        put(CMD_CLOSE, 8'h5A);
        // bad size character, empty size, close mid-body
        put(CMD_RESTART, 8'hFF);
        put_text("g");
        put(CMD_RESTART, 8'h00);
        put_text(";");
        put(CMD_RESTART, 8'h00);
        put(CMD_CLOSE, 8'hA5);
        n_directed = stim_q.size();
        while (stim_q.size() < NUM_ITEMS)
            put_body();
    endtask

    // Result side stalls
    initial
    begin
        res_stall  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                res_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                res_stall <= 1'b0;
                if (!no_idle && $urandom_range(0, 3) == 0)
                    stall_left = idle_len();
            end
        end
    end

    initial
    begin
        int gap;
        int half;
        bit drain;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        command  = CMD_BYTE;
        in_byte  = 8'h00;
        no_idle  = 1'b0;
        build_stimulus();
        half = stim_q.size() / 2;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        for (int i = 0; i < stim_q.size(); i++)
        begin
            no_idle = (i % 500) >= 250 && (i % 500) < 330;
            gap = no_idle ? 0 : (($urandom_range(0, 2) == 0) ? idle_len() : 0);
            drain = (i == n_directed || i == half);
            if (drain && gap == 0)
                gap = 1;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
                // hold off until the decoder has answered everything sent so far
                if (drain)
                    while (pending != 0) @(negedge clk);
            end
            in_valid <= 1'b1;
            command  <= stim_q[i].cmd;
            in_byte  <= stim_q[i].data;
            do @(posedge clk); while (in_stall);
            @(negedge clk);
        end
        in_valid <= 1'b0;
        no_idle = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        $display("covered %0d transfers (%0d directed), %0d payload bytes out",
                 stim_q.size(), n_directed, n_payload);
        $display("bodies completed %0d, bodies rejected %0d", n_ok, n_bad);
        if (fail_count == 0 && pending == 0)
            $display("http_chunked_body_decoder_core: match");
        else
            $display("http_chunked_body_decoder_core: mismatch");
        $finish;
    end

endmodule
